### rtl/ptct_pkg.sv
package ptct_pkg;

   // Coordinate format: signed two's complement, Q8.8 at 16 bits
   localparam int COORD_BITS = 16;
   localparam int VEC_BITS   = 3 * COORD_BITS;        // packed z,y,x
   localparam int DIFF_BITS  = COORD_BITS + 1;        // vertex difference
   localparam int CROSS_BITS = 2 * DIFF_BITS + 1;     // cross product component
   localparam int HSUM_BITS  = CROSS_BITS + 2;        // n - g2 - g3 component

   typedef struct packed {
      logic [VEC_BITS-1:0] tri_a_now;
      logic [VEC_BITS-1:0] tri_b_now;
      logic [VEC_BITS-1:0] tri_c_now;
      logic [VEC_BITS-1:0] tri_a_before;
      logic [VEC_BITS-1:0] tri_b_before;
      logic [VEC_BITS-1:0] tri_c_before;
      logic [VEC_BITS-1:0] point_now;
      logic [VEC_BITS-1:0] point_before;
      logic                history_valid;
   } ptct_req_type;

   typedef struct packed {
      logic pierces;
      logic plane_crossed;
      logic inside_triangle;
   } ptct_rsp_type;

   // sign of an exact dot product
   typedef struct packed {
      logic neg;
      logic zero;
   } ptct_sign_type;

endpackage

### rtl/ptct_dot3.sv
// Exact sign of a 3-element signed dot product, three register stages:
// split partial products, per-lane product, lane sum.
module ptct_dot3 #(
   parameter int AW = ptct_pkg::CROSS_BITS,
   parameter int BW = ptct_pkg::DIFF_BITS
) (
   input  logic                        clock,
   input  logic [2:0]                  en,     // stage load enables, [0] first
   input  logic [2:0][AW-1:0]          a,
   input  logic [2:0][BW-1:0]          b,
   output ptct_pkg::ptct_sign_type     sign
);

   localparam int LA = AW / 2;
   localparam int HA = AW - LA;
   localparam int LB = BW / 2;
   localparam int HB = BW - LB;
   localparam int PW = AW + BW;
   localparam int SW = PW + 2;

   logic signed [HA+HB-1:0]  hh_in [3];
   logic signed [HA+HB-1:0]  hh_ff [3];
   logic signed [HA+LB:0]    hl_in [3];
   logic signed [HA+LB:0]    hl_ff [3];
   logic signed [LA+HB:0]    lh_in [3];
   logic signed [LA+HB:0]    lh_ff [3];
   logic        [LA+LB-1:0]  ll_in [3];
   logic        [LA+LB-1:0]  ll_ff [3];
   logic signed [PW-1:0]     prod_in [3];
   logic signed [PW-1:0]     prod_ff [3];
   logic signed [SW-1:0]     sum_in;
   ptct_pkg::ptct_sign_type  sign_ff;

   for (genvar i = 0; i < 3; i++) begin : g_lane
      // high halves signed, low halves unsigned
      assign hh_in[i] = $signed(a[i][AW-1:LA]) * $signed(b[i][BW-1:LB]);
      assign hl_in[i] = $signed(a[i][AW-1:LA]) * $signed({1'b0, b[i][LB-1:0]});
      assign lh_in[i] = $signed({1'b0, a[i][LA-1:0]}) * $signed(b[i][BW-1:LB]);
      assign ll_in[i] = a[i][LA-1:0] * b[i][LB-1:0];

      assign prod_in[i] = (PW'(hh_ff[i]) << (LA + LB)) + (PW'(hl_ff[i]) << LA)
                        + (PW'(lh_ff[i]) << LB) + PW'(ll_ff[i]);

      always_ff @(posedge clock) begin
         if (en[0]) begin
            hh_ff[i] <= hh_in[i];
            hl_ff[i] <= hl_in[i];
            lh_ff[i] <= lh_in[i];
            ll_ff[i] <= ll_in[i];
         end
         if (en[1]) begin
            prod_ff[i] <= prod_in[i];
         end
      end
   end

   assign sum_in = SW'(prod_ff[0]) + SW'(prod_ff[1]) + SW'(prod_ff[2]);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         sign_ff.neg  <= sum_in[SW-1];
         sign_ff.zero <= (sum_in == '0);
      end
   end

   assign sign = sign_ff;

endmodule

### rtl/point_triangle_crossing_test_unit.sv
// Channel   Direction  Handshake            Beat
// req       in         req_valid/req_ready  ptct_req_type: two triangles, two points, history
// rsp       out        rsp_valid/rsp_ready  ptct_rsp_type: pierces, plane_crossed, inside
//
// Seven register stages; one beat in and one out per cycle while rsp_ready is high.
// rsp_valid is the registered valid bit of stage 7.
// The depth is set by the split dot products, up to 35x37 bits (partials, product, sum).
// reset is synchronous and clears only the stage valid bits.
// Each stage holds while the stage after it is full and stalled; empty stages
// keep filling, so bubbles close up and nothing is dropped or repeated.
module point_triangle_crossing_test_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ptct_pkg::ptct_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ptct_pkg::ptct_rsp_type rsp_data
);

   localparam int CB  = ptct_pkg::COORD_BITS;
   localparam int DB  = ptct_pkg::DIFF_BITS;
   localparam int XB  = ptct_pkg::CROSS_BITS;
   localparam int HB  = ptct_pkg::HSUM_BITS;
   localparam int NST = 7;

   typedef logic [2:0][DB-1:0] dvec_type;
   typedef logic [2:0][XB-1:0] cvec_type;
   typedef logic [2:0][HB-1:0] hvec_type;

   // Component-wise difference of two packed points
   function automatic dvec_type vdiff(input logic [ptct_pkg::VEC_BITS-1:0] u,
                                      input logic [ptct_pkg::VEC_BITS-1:0] w);
      dvec_type r;
      for (int k = 0; k < 3; k++) begin
         r[k] = DB'($signed(u[k*CB +: CB])) - DB'($signed(w[k*CB +: CB]));
      end
      return r;
   endfunction

   // p*q - s*t, exact
   function automatic logic signed [XB-1:0] mulsub(input logic signed [DB-1:0] p,
                                                   input logic signed [DB-1:0] q,
                                                   input logic signed [DB-1:0] s,
                                                   input logic signed [DB-1:0] t);
      logic signed [2*DB-1:0] pq;
      logic signed [2*DB-1:0] st;
      pq = p * q;
      st = s * t;
      return XB'(pq) - XB'(st);
   endfunction

   function automatic cvec_type cross3(input dvec_type u, input dvec_type v);
      cvec_type r;
      r[0] = mulsub(u[1], v[2], u[2], v[1]);
      r[1] = mulsub(u[2], v[0], u[0], v[2]);
      r[2] = mulsub(u[0], v[1], u[1], v[0]);
      return r;
   endfunction

   // ---------------- stage control ----------------
   logic [NST:1] en;
   logic [NST:1] vld_ff;
   logic [NST:1] vld_in;

   always_comb begin
      en[NST] = !vld_ff[NST] || rsp_ready;
      for (int k = NST - 1; k >= 1; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   always_comb begin
      vld_in[1] = en[1] ? req_valid : vld_ff[1];
      for (int k = 2; k <= NST; k++) begin
         vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = en[1];

   // ---------------- stage 1: edge and offset vectors ----------------
   // e1 = A-B, e2 = A-C, f1 = A'-B', f2 = B'-C', dp = P-A, dq = P'-A'
   dvec_type e1_in, e2_in, f1_in, f2_in, dp1_in, dq1_in;
   dvec_type e1_ff, e2_ff, f1_ff, f2_ff, dp1_ff, dq1_ff;
   logic     hist1_ff;

   assign e1_in  = vdiff(req_data.tri_a_now, req_data.tri_b_now);
   assign e2_in  = vdiff(req_data.tri_a_now, req_data.tri_c_now);
   assign f1_in  = vdiff(req_data.tri_a_before, req_data.tri_b_before);
   assign f2_in  = vdiff(req_data.tri_b_before, req_data.tri_c_before);
   assign dp1_in = vdiff(req_data.point_now, req_data.tri_a_now);
   assign dq1_in = vdiff(req_data.point_before, req_data.tri_a_before);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         e1_ff    <= e1_in;
         e2_ff    <= e2_in;
         f1_ff    <= f1_in;
         f2_ff    <= f2_in;
         dp1_ff   <= dp1_in;
         dq1_ff   <= dq1_in;
         hist1_ff <= req_data.history_valid;
      end
   end

   // ---------------- stage 2: cross products ----------------
   // n is both the current normal and the barycentric edge cross (B-A)x(C-A).
   // Barycentric numerators by Binet-Cauchy: v = n.(e2 x dp), w = n.(dp x e1),
   // u = |n|^2 - v - w = n.(n - g2 - g3); the Gram determinant is |n|^2.
   cvec_type n2_in, m2_in, g2_in, g3_in;
   cvec_type n2_ff, m2_ff, g2_ff, g3_ff;
   dvec_type dp2_ff, dq2_ff;
   logic     hist2_ff;

   assign n2_in = cross3(e1_ff, e2_ff);
   assign m2_in = cross3(f1_ff, f2_ff);
   assign g2_in = cross3(e2_ff, dp1_ff);
   assign g3_in = cross3(dp1_ff, e1_ff);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         n2_ff    <= n2_in;
         m2_ff    <= m2_in;
         g2_ff    <= g2_in;
         g3_ff    <= g3_in;
         dp2_ff   <= dp1_ff;
         dq2_ff   <= dq1_ff;
         hist2_ff <= hist1_ff;
      end
   end

   // ---------------- stage 3: u-term vector, degeneracy flag ----------------
   hvec_type h3_in, h3_ff;
   cvec_type n3_ff, m3_ff, g2_3_ff, g3_3_ff;
   dvec_type dp3_ff, dq3_ff;
   logic     hist3_ff, nz3_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         h3_in[k] = HB'($signed(n2_ff[k])) - HB'($signed(g2_ff[k]))
                  - HB'($signed(g3_ff[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         h3_ff    <= h3_in;
         n3_ff    <= n2_ff;
         m3_ff    <= m2_ff;
         g2_3_ff  <= g2_ff;
         g3_3_ff  <= g3_ff;
         dp3_ff   <= dp2_ff;
         dq3_ff   <= dq2_ff;
         hist3_ff <= hist2_ff;
         nz3_ff   <= (n2_ff != '0);     // zero normal: degenerate triangle
      end
   end

   // ---------------- stages 4..6: six exact dot-product signs ----------------
   ptct_pkg::ptct_sign_type s_ndp, s_mdq, s_nm, s_v, s_w, s_u;

   ptct_dot3 #(.AW(XB), .BW(DB)) u_dot_ndp (
      .clock(clock), .en(en[6:4]), .a(n3_ff), .b(dp3_ff), .sign(s_ndp));
   ptct_dot3 #(.AW(XB), .BW(DB)) u_dot_mdq (
      .clock(clock), .en(en[6:4]), .a(m3_ff), .b(dq3_ff), .sign(s_mdq));
   ptct_dot3 #(.AW(XB), .BW(XB)) u_dot_nm (
      .clock(clock), .en(en[6:4]), .a(n3_ff), .b(m3_ff), .sign(s_nm));
   ptct_dot3 #(.AW(XB), .BW(XB)) u_dot_v (
      .clock(clock), .en(en[6:4]), .a(n3_ff), .b(g2_3_ff), .sign(s_v));
   ptct_dot3 #(.AW(XB), .BW(XB)) u_dot_w (
      .clock(clock), .en(en[6:4]), .a(n3_ff), .b(g3_3_ff), .sign(s_w));
   ptct_dot3 #(.AW(XB), .BW(HB)) u_dot_u (
      .clock(clock), .en(en[6:4]), .a(n3_ff), .b(h3_ff), .sign(s_u));

   // flags riding alongside the dot units
   logic [6:4] hist_ff, nz_ff;

   always_ff @(posedge clock) begin
      if (en[4]) begin
         hist_ff[4] <= hist3_ff;
         nz_ff[4]   <= nz3_ff;
      end
      if (en[5]) begin
         hist_ff[5] <= hist_ff[4];
         nz_ff[5]   <= nz_ff[4];
      end
      if (en[6]) begin
         hist_ff[6] <= hist_ff[5];
         nz_ff[6]   <= nz_ff[5];
      end
   end

   // ---------------- stage 7: result register ----------------
   // Past distance flips sign when the past normal disagrees with the current.
   // Crossing needs both distances nonzero and of opposite sign.
   logic                   crossed_in, inside_in;
   ptct_pkg::ptct_rsp_type rsp_in, rsp_ff;

   assign crossed_in = hist_ff[6] && !s_ndp.zero && !s_mdq.zero
                    && (s_ndp.neg != (s_mdq.neg ^ s_nm.neg));
   assign inside_in  = nz_ff[6] && !s_u.neg && !s_v.neg && !s_w.neg;

   always_comb begin
      rsp_in.pierces         = crossed_in && inside_in;
      rsp_in.plane_crossed   = crossed_in;
      rsp_in.inside_triangle = inside_in;
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = vld_ff[NST];
   assign rsp_data  = rsp_ff;

endmodule
